/* hw/rtl/sls_pkg.sv */
// Step list sequencer package: command and status codes, action codes and defaults.
// Used by step_list_sequencer; depends on nothing else.

package sls_pkg;

  // Default step table size.
  localparam int unsigned MaxSteps = 16;

  // Widths fixed by the transaction fields.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned IdxInW  = 4;
  localparam int unsigned ActW    = 4;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned TargetW = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned TotalW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdLoad    = 3'd0,
    CmdRun     = 3'd1,
    CmdStop    = 3'd2,
    CmdTick    = 3'd3,
    CmdAdvance = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StIdle = 2'd0,
    StRun  = 2'd1,
    StWait = 2'd2,
    StDone = 2'd3
  } run_st_e;

  typedef enum logic [ActW-1:0] {
    ActNone     = 4'd0,
    ActWait     = 4'd5,
    ActLoop     = 4'd10,
    ActAnchor   = 4'd14,
    ActReserved = 4'd15
  } act_e;

endpackage

/* hw/rtl/step_list_sequencer.sv */
// Step list sequencer: step table, loop counters, wait timer and anchor store.
// Depends on sls_pkg.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one command per transaction:
//   load step, run, stop, tick or advance, plus the step fields and the tick's
//   elapsed time (unsigned Q8.8 seconds). Loads are taken only while idle or
//   done. Every accepted transaction produces exactly one result transaction on
//   the output channel (out_valid_o / out_ready_i): the emitted action (zero when
//   none), the step pointer, the status, the step-valid flag and the anchor.
//   The command is held in an input register, then the table read, timer and
//   pointer update run as one short combinational pass into the result
//   register, which presents the result on the output. Throughput is one
//   transaction per cycle while out_ready_i does not stall the result
//   register, as the pointer and state registers update once per
//   transaction.
//   Stall: while a result waits on out_ready_i the input register is still
//   free to take one more transaction; only when both are full does
//   in_ready_o drop.
//   Reset: state goes idle, pointer, timer, loop counters and anchor clear.
//   The step table itself is not cleared; only loaded slots are meaningful.

module step_list_sequencer #(
  parameter int unsigned MAX_STEPS = sls_pkg::MaxSteps
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [sls_pkg::CmdW-1:0]      command_i,
  input  logic        [sls_pkg::IdxInW-1:0]    step_index_i,
  input  logic        [sls_pkg::ActW-1:0]      step_action_i,
  input  logic signed [sls_pkg::CoordW-1:0]    step_q_i,
  input  logic signed [sls_pkg::CoordW-1:0]    step_r_i,
  input  logic signed [sls_pkg::CoordW-1:0]    step_layer_i,
  input  logic        [sls_pkg::TimeW-1:0]     step_wait_i,
  input  logic signed [sls_pkg::TargetW-1:0]   step_from_i,
  input  logic        [sls_pkg::CountW-1:0]    step_loop_count_i,
  input  logic        [sls_pkg::TotalW-1:0]    step_total_i,
  input  logic        [sls_pkg::TimeW-1:0]     elapsed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [sls_pkg::ActW-1:0]      action_o,
  output logic        [sls_pkg::TotalW-1:0]    step_now_o,
  output logic        [sls_pkg::StatusW-1:0]   status_o,
  output logic                                 step_valid_o,
  output logic signed [sls_pkg::CoordW-1:0]    home_q_o,
  output logic signed [sls_pkg::CoordW-1:0]    home_r_o,
  output logic signed [sls_pkg::CoordW-1:0]    home_layer_o,
  output logic                                 anchor_valid_o
);

  import sls_pkg::*;

  // Only sixteen slots are addressable by a load, so the table never needs more.
  localparam int unsigned SlotLimit = 1 << IdxInW;
  localparam int unsigned TblDepth  = (MAX_STEPS < SlotLimit) ? MAX_STEPS : SlotLimit;
  localparam int unsigned IdxW      = $clog2(TblDepth);
  // The step total is at most 31, so the loaded count and pointer never exceed that.
  localparam int unsigned TotalMax  = (1 << TotalW) - 1;
  localparam int unsigned LoadMax   = (MAX_STEPS < TotalMax) ? MAX_STEPS : TotalMax;
  localparam int unsigned PtrW      = $clog2(LoadMax + 1);
  localparam int unsigned CmpW      = 10;

  // ---------------------------------------------------------------------------
  // Step table and loop counters
  // ---------------------------------------------------------------------------
  logic        [ActW-1:0]    tbl_act_q   [TblDepth];
  logic signed [CoordW-1:0]  tbl_q_q     [TblDepth];
  logic signed [CoordW-1:0]  tbl_r_q     [TblDepth];
  logic signed [CoordW-1:0]  tbl_layer_q [TblDepth];
  logic        [TimeW-1:0]   tbl_wait_q  [TblDepth];
  logic signed [TargetW-1:0] tbl_from_q  [TblDepth];
  logic        [CountW-1:0]  tbl_count_q [TblDepth];
  logic        [CountW-1:0]  loops_left_q[TblDepth];

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                      in_valid_q;
  logic        [CmdW-1:0]    in_cmd_q;
  logic        [IdxInW-1:0]  in_idx_q;
  logic        [ActW-1:0]    in_act_q;
  logic signed [CoordW-1:0]  in_q_q;
  logic signed [CoordW-1:0]  in_r_q;
  logic signed [CoordW-1:0]  in_layer_q;
  logic        [TimeW-1:0]   in_wait_q;
  logic signed [TargetW-1:0] in_from_q;
  logic        [CountW-1:0]  in_count_q;
  logic        [TotalW-1:0]  in_total_q;
  logic        [TimeW-1:0]   in_elapsed_q;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  run_st_e                   st_q, st_d;
  logic        [PtrW-1:0]    ptr_q, ptr_d;
  logic        [PtrW-1:0]    loaded_q, loaded_d;
  logic        [TimeW-1:0]   wait_left_q, wait_left_d;
  logic signed [CoordW-1:0]  anc_q_q, anc_q_d;
  logic signed [CoordW-1:0]  anc_r_q, anc_r_d;
  logic signed [CoordW-1:0]  anc_layer_q, anc_layer_d;
  logic                      anc_flag_q, anc_flag_d;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                      out_valid_q;
  logic        [ActW-1:0]    out_act_q;
  logic        [PtrW-1:0]    out_ptr_q;
  logic        [StatusW-1:0] out_status_q;
  logic                      out_step_valid_q;

  // Handshake: the result register frees when empty or being taken.
  logic advance;
  logic fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_cmd_q     <= command_i;
      in_idx_q     <= step_index_i;
      in_act_q     <= step_action_i;
      in_q_q       <= step_q_i;
      in_r_q       <= step_r_i;
      in_layer_q   <= step_layer_i;
      in_wait_q    <= step_wait_i;
      in_from_q    <= step_from_i;
      in_count_q   <= step_loop_count_i;
      in_total_q   <= step_total_i;
      in_elapsed_q <= elapsed_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Single pass: decode the held command and work out the next state
  // ---------------------------------------------------------------------------
  logic                   tbl_we;
  logic                   reload;
  logic                   loop_dec;
  logic [ActW-1:0]        emit;
  logic                   go;
  logic [PtrW-1:0]        cur;
  logic [IdxW-1:0]        rd_idx;
  logic [ActW-1:0]        rd_act;
  logic [TimeW-1:0]       remain;
  logic                   target_ok;
  logic                   slot_ok;
  logic [PtrW-1:0]        ptr_inc;
  logic [PtrW-1:0]        cur_inc;

  assign slot_ok = (CmpW'(in_idx_q) < CmpW'(TblDepth));
  assign remain  = (wait_left_q > in_elapsed_q) ? (wait_left_q - in_elapsed_q) : '0;
  assign ptr_inc = PtrW'(ptr_q + 1'b1);

  always_comb begin
    st_d        = st_q;
    ptr_d       = ptr_q;
    loaded_d    = loaded_q;
    wait_left_d = wait_left_q;
    anc_q_d     = anc_q_q;
    anc_r_d     = anc_r_q;
    anc_layer_d = anc_layer_q;
    anc_flag_d  = anc_flag_q;
    tbl_we      = 1'b0;
    reload      = 1'b0;
    loop_dec    = 1'b0;
    emit        = '0;
    go          = 1'b0;
    cur         = ptr_q;

    // Timer expiry moves past the wait step before the rules are applied.
    if (st_q == StWait) begin
      if (remain == '0) begin
        go  = 1'b1;
        cur = ptr_inc;
      end
    end else if (st_q == StRun) begin
      go = 1'b1;
    end

    cur_inc   = PtrW'(cur + 1'b1);
    rd_idx    = cur[IdxW-1:0];
    rd_act    = tbl_act_q[rd_idx];
    target_ok = !tbl_from_q[rd_idx][TargetW-1] &&
                (TargetW'(tbl_from_q[rd_idx]) < TargetW'(loaded_q));

    unique case (in_cmd_q)
      CmdLoad: begin
        tbl_we = (st_q == StIdle || st_q == StDone) && slot_ok;
      end
      CmdRun: begin
        loaded_d    = (CmpW'(in_total_q) > CmpW'(MAX_STEPS)) ? PtrW'(MAX_STEPS)
                                                            : PtrW'(in_total_q);
        st_d        = StRun;
        ptr_d       = '0;
        wait_left_d = '0;
        anc_flag_d  = 1'b0;
        reload      = 1'b1;
      end
      CmdStop: begin
        st_d  = StIdle;
        ptr_d = '0;
      end
      CmdTick: begin
        // Only a tick runs the timer down.
        if (st_q == StWait) begin
          wait_left_d = remain;
        end
        if (go) begin
          st_d  = StRun;
          ptr_d = cur;
          if (cur >= loaded_q) begin
            st_d = StDone;
          end else begin
            unique case (rd_act) inside
              ActWait: begin
                st_d        = StWait;
                wait_left_d = tbl_wait_q[rd_idx];
              end
              ActLoop: begin
                ptr_d = cur_inc;
                if (loops_left_q[rd_idx] != '0) begin
                  loop_dec = 1'b1;
                  if (target_ok) begin
                    ptr_d = PtrW'(tbl_from_q[rd_idx]);
                  end
                end
              end
              ActAnchor: begin
                if (tbl_q_q[rd_idx] != '0 || tbl_r_q[rd_idx] != '0) begin
                  anc_q_d     = tbl_q_q[rd_idx];
                  anc_r_d     = tbl_r_q[rd_idx];
                  anc_layer_d = tbl_layer_q[rd_idx];
                end
                anc_flag_d = 1'b1;
                ptr_d      = cur_inc;
              end
              ActNone, ActReserved: begin
                ptr_d = cur_inc;
              end
              default: begin
                emit = rd_act;
              end
            endcase
          end
        end else begin
          // Hold the pointer while the timer runs down, or while idle or done.
          ptr_d = ptr_q;
        end
      end
      CmdAdvance: begin
        if (st_q == StRun) begin
          ptr_d = ptr_inc;
          if (ptr_inc >= loaded_q) begin
            st_d = StDone;
          end
        end
      end
      default: begin
        // Unknown command: change nothing.
      end
    endcase

    if (!fire) begin
      st_d        = st_q;
      ptr_d       = ptr_q;
      loaded_d    = loaded_q;
      wait_left_d = wait_left_q;
      anc_q_d     = anc_q_q;
      anc_r_d     = anc_r_q;
      anc_layer_d = anc_layer_q;
      anc_flag_d  = anc_flag_q;
      tbl_we      = 1'b0;
      reload      = 1'b0;
      loop_dec    = 1'b0;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      ptr_q       <= '0;
      loaded_q    <= '0;
      wait_left_q <= '0;
      anc_q_q     <= '0;
      anc_r_q     <= '0;
      anc_layer_q <= '0;
      anc_flag_q  <= 1'b0;
    end else begin
      st_q        <= st_d;
      ptr_q       <= ptr_d;
      loaded_q    <= loaded_d;
      wait_left_q <= wait_left_d;
      anc_q_q     <= anc_q_d;
      anc_r_q     <= anc_r_d;
      anc_layer_q <= anc_layer_d;
      anc_flag_q  <= anc_flag_d;
    end
  end

  // Step table: written by a load, no reset.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_act_q[in_idx_q[IdxW-1:0]]   <= in_act_q;
      tbl_q_q[in_idx_q[IdxW-1:0]]     <= in_q_q;
      tbl_r_q[in_idx_q[IdxW-1:0]]     <= in_r_q;
      tbl_layer_q[in_idx_q[IdxW-1:0]] <= in_layer_q;
      tbl_wait_q[in_idx_q[IdxW-1:0]]  <= in_wait_q;
      tbl_from_q[in_idx_q[IdxW-1:0]]  <= in_from_q;
      tbl_count_q[in_idx_q[IdxW-1:0]] <= in_count_q;
    end
  end

  // Loop counters: reload all in parallel on run, spend one on a loop step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblDepth; i++) begin
        loops_left_q[i] <= '0;
      end
    end else if (reload) begin
      for (int i = 0; i < TblDepth; i++) begin
        loops_left_q[i] <= tbl_count_q[i];
      end
    end else if (loop_dec) begin
      loops_left_q[rd_idx] <= loops_left_q[rd_idx] - 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_act_q        <= emit;
      out_ptr_q        <= ptr_d;
      out_status_q     <= st_d;
      out_step_valid_q <= (st_d == StRun) && (ptr_d < loaded_d);
    end
  end

  // The anchor outputs show the live anchor, which only moves with a result.
  assign out_valid_o    = out_valid_q;
  assign action_o       = out_act_q;
  assign step_now_o     = TotalW'(out_ptr_q);
  assign status_o       = out_status_q;
  assign step_valid_o   = out_step_valid_q;
  assign home_q_o       = anc_q_q;
  assign home_r_o       = anc_r_q;
  assign home_layer_o   = anc_layer_q;
  assign anchor_valid_o = anc_flag_q;

`ifndef SYNTHESIS
  // A step is valid only while running.
  a_step_valid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_valid_o |-> status_o == StRun)
    else $error("step valid outside running status");

  // An emitted action always refers to a live step.
  a_emit_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != '0 |-> step_valid_o)
    else $error("action emitted without a valid step");

  // Idle always parks the pointer at zero.
  a_idle_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StIdle |-> step_now_o == '0)
    else $error("idle status with nonzero pointer");

  // Input stalls only when both the input and result registers are full.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with free register");
`endif

endmodule
